// File: design/cac_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Contiguous access coalescer package
// Word types, the queue record and shared constants of the coalescer.
// ----------------------------------------------------------------------------
package cac_pkg;

  localparam int unsigned ADDR_W       = 32;
  localparam int unsigned INDEX_W      = 64;
  localparam int unsigned SIZE_W       = 8;
  localparam int unsigned BYTES_W      = 32;
  localparam int unsigned COUNT_W      = 32;
  localparam int unsigned STEP_W       = 32;
  localparam int unsigned BYTE_SHIFT   = 3;
  localparam int unsigned QUEUE_DEPTH  = 4;
  localparam logic [BYTES_W-1:0] MIN_SIZE_RESET = 32'd4;

  typedef struct packed {
    logic [ADDR_W-1:0]  access_addr;
    logic [INDEX_W-1:0] trace_index;
    logic [SIZE_W-1:0]  size_bits;
    logic               end_of_stream;
  } in_word_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  buffer_start;
    logic [BYTES_W-1:0] buffer_bytes;
    logic [COUNT_W-1:0] merged_count;
    logic               last_of_run;
  } out_word_t;

  // Results of one input: the buffer it closed, then its own closed buffer.
  typedef struct packed {
    logic      close_valid;
    out_word_t close_word;
    logic      own_valid;
    out_word_t own_word;
  } rec_t;

endpackage : cac_pkg
`default_nettype wire

// File: design/contiguous_access_coalescer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Contiguous access coalescer
// Merges a stream of memory accesses into contiguous buffers and reports
// the closed buffers that are larger than min_size bytes.
// ----------------------------------------------------------------------------
// The block accepts one access per clock cycle while the queue has room.
// The front end updates the open buffer in the cycle of acceptance and
// writes any closed buffers into a queue of QUEUE_DEPTH records; the back
// end delivers them one word per cycle while out_ready is high, each word
// held in the queue and then in the back end. An access that closes two
// buffers yields two words, so the sustained rate is one access per cycle
// unless the output stalls or double results are frequent, in which case
// the queue fills and in_ready drops. min_size may be written at any time
// through the cfg channel, which is always ready.
module contiguous_access_coalescer #(
  parameter int unsigned QUEUE_DEPTH = cac_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire cac_pkg::in_word_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output cac_pkg::out_word_t      out_data
);

  logic          q_full;
  logic          q_push;
  logic          q_pop;
  logic          q_not_empty;
  cac_pkg::rec_t q_wr_rec;
  cac_pkg::rec_t q_rd_rec;

  cac_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_rec     (q_wr_rec)
  );

  cac_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wr_rec    (q_wr_rec),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rd_rec    (q_rd_rec)
  );

  cac_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_rec       (q_rd_rec),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule : contiguous_access_coalescer
`default_nettype wire

// File: design/cac_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Coalescer front end
// Accepts accesses, merges them into the open buffer and pushes the buffers
// that close into the result queue.
// ----------------------------------------------------------------------------
module cac_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [31:0]      cfg_data,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire cac_pkg::in_word_t in_data,
  input  wire logic             q_full,
  output logic                  q_push,
  output cac_pkg::rec_t         q_rec
);

  logic [cac_pkg::BYTES_W-1:0] min_size;
  logic                        buffer_open;
  logic [cac_pkg::ADDR_W-1:0]  base_address;
  logic [cac_pkg::BYTES_W-1:0] accumulated_bytes;
  logic [cac_pkg::STEP_W-1:0]  index_step;
  logic                        step_fixed;
  logic [cac_pkg::INDEX_W-1:0] previous_index;
  logic [cac_pkg::COUNT_W-1:0] access_count;

  logic                        accept;
  logic [cac_pkg::BYTES_W-1:0] bytes;
  logic [cac_pkg::ADDR_W-1:0]  end_addr;
  logic [cac_pkg::INDEX_W-1:0] diff;
  logic                        merge;
  logic [cac_pkg::BYTES_W-1:0] acc_sum;
  logic [cac_pkg::COUNT_W-1:0] count_inc;
  logic                        close_emit;
  logic                        own_emit;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;

  assign bytes     = cac_pkg::BYTES_W'(in_data.size_bits >> cac_pkg::BYTE_SHIFT);
  assign end_addr  = base_address + accumulated_bytes;
  assign diff      = in_data.trace_index - previous_index;
  assign merge     = buffer_open && (end_addr == in_data.access_addr) &&
                     (!step_fixed ||
                      (diff == {{(cac_pkg::INDEX_W-cac_pkg::STEP_W){1'b0}}, index_step}));
  assign acc_sum   = accumulated_bytes + bytes;
  assign count_inc = (access_count == '1) ? access_count : access_count + 1'b1;

  always_comb begin
    close_emit = buffer_open && !merge && (accumulated_bytes > min_size);
    if (merge) begin
      own_emit = in_data.end_of_stream && (acc_sum > min_size);
    end else begin
      own_emit = in_data.end_of_stream && (bytes > min_size);
    end

    q_rec.close_valid             = close_emit;
    q_rec.close_word.buffer_start = base_address;
    q_rec.close_word.buffer_bytes = accumulated_bytes;
    q_rec.close_word.merged_count = access_count;
    q_rec.close_word.last_of_run  = !own_emit;

    q_rec.own_valid               = own_emit;
    q_rec.own_word.buffer_start   = merge ? base_address : in_data.access_addr;
    q_rec.own_word.buffer_bytes   = merge ? acc_sum : bytes;
    q_rec.own_word.merged_count   = merge ? count_inc : cac_pkg::COUNT_W'(1);
    q_rec.own_word.last_of_run    = 1'b1;

    q_push = accept && (close_emit || own_emit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_size          <= cac_pkg::MIN_SIZE_RESET;
      buffer_open       <= 1'b0;
      base_address      <= '0;
      accumulated_bytes <= '0;
      index_step        <= '0;
      step_fixed        <= 1'b0;
      previous_index    <= '0;
      access_count      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        min_size <= cfg_data;
      end
      if (accept) begin
        if (merge) begin
          accumulated_bytes <= acc_sum;
          access_count      <= count_inc;
          previous_index    <= in_data.trace_index;
          if (!step_fixed) begin
            index_step <= diff[cac_pkg::STEP_W-1:0];
            step_fixed <= 1'b1;
          end
        end else begin
          base_address      <= in_data.access_addr;
          accumulated_bytes <= bytes;
          index_step        <= '0;
          step_fixed        <= 1'b0;
          previous_index    <= in_data.trace_index;
          access_count      <= cac_pkg::COUNT_W'(1);
        end
        buffer_open <= !in_data.end_of_stream;
      end
    end
  end

  a_eos_closes: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.end_of_stream |=> !buffer_open)
    else $error("buffer still open after end of stream");

  a_open_has_count: assert property (@(posedge clk) disable iff (rst)
    buffer_open |-> access_count != '0)
    else $error("open buffer with zero merged accesses");

endmodule : cac_front
`default_nettype wire

// File: design/cac_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Coalescer result queue
// Small flip-flop queue of result records between front end and back end.
// ----------------------------------------------------------------------------
module cac_queue #(
  parameter int unsigned DEPTH = cac_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire cac_pkg::rec_t wr_rec,
  output logic               full,
  input  wire logic          pop,
  output logic               not_empty,
  output cac_pkg::rec_t      rd_rec
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cac_pkg::rec_t   mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign rd_rec    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !not_empty |-> !pop)
    else $error("pop from an empty queue");

endmodule : cac_queue
`default_nettype wire

// File: design/cac_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Coalescer back end
// Takes result records from the queue and delivers their words one by one.
// ----------------------------------------------------------------------------
module cac_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_not_empty,
  input  wire cac_pkg::rec_t q_rec,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output cac_pkg::out_word_t out_data
);

  cac_pkg::rec_t cur;
  logic          close_pending;
  logic          own_pending;
  logic          out_accept;
  logic          drained;

  assign out_valid  = close_pending || own_pending;
  assign out_data   = close_pending ? cur.close_word : cur.own_word;
  assign out_accept = out_valid && out_ready;
  assign drained    = !out_valid || (out_accept && !(close_pending && own_pending));
  assign q_pop      = q_not_empty && drained;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      close_pending <= 1'b0;
      own_pending   <= 1'b0;
    end else if (q_pop) begin
      close_pending <= q_rec.close_valid;
      own_pending   <= q_rec.own_valid;
    end else if (out_accept) begin
      if (close_pending) begin
        close_pending <= 1'b0;
      end else begin
        own_pending <= 1'b0;
      end
    end
  end

  a_rec_not_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_rec.close_valid || q_rec.own_valid)
    else $error("empty record taken from the queue");

  a_second_word: assert property (@(posedge clk) disable iff (rst)
    out_accept && close_pending && own_pending |=> out_valid && !close_pending)
    else $error("second word of a record lost");

endmodule : cac_back
`default_nettype wire
